// ----- rtl/stlb_pkg.sv -----
// ----------------------------------------------------------------------------
// Split TLB package
// Shared constants and types for the split instruction and data TLB.
// ----------------------------------------------------------------------------
`default_nettype none

package stlb_pkg;

  localparam int unsigned PAGE_W = 32;
  localparam int unsigned SLOT_W = 4;
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned CFG_W  = 5;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;
  localparam logic [CNT_W-1:0] CNT_MAX   = 32'hFFFF_FFFF;

  typedef enum logic {
    TLB_INSTR = 1'b0,
    TLB_DATA  = 1'b1
  } tlb_sel_e;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  hit_count;
    logic [CNT_W-1:0]  miss_count;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/stlb_if.sv -----
// ----------------------------------------------------------------------------
// Split TLB channel interfaces
// Request, response and configuration channels with valid and ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface stlb_req_if;
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [stlb_pkg::PAGE_W-1:0]  page_number;

  modport source (output valid, action, page_number, input ready);
  modport sink   (input valid, action, page_number, output ready);
endinterface

interface stlb_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic [stlb_pkg::SLOT_W-1:0]  slot;
  logic [stlb_pkg::CNT_W-1:0]   hit_count;
  logic [stlb_pkg::CNT_W-1:0]   miss_count;

  modport source (output valid, hit, slot, hit_count, miss_count, input ready);
  modport sink   (input valid, hit, slot, hit_count, miss_count, output ready);
endinterface

interface stlb_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [stlb_pkg::CFG_W-1:0]   entries_in_use;

  modport source (output valid, entries_in_use, input ready);
  modport sink   (input valid, entries_in_use, output ready);
endinterface

`default_nettype wire

// ----- rtl/stlb_front.sv -----
// ----------------------------------------------------------------------------
// Split TLB front end
// Accepts request words, selects the TLB and trims the page to a tag.
// ----------------------------------------------------------------------------
`default_nettype none

module stlb_front #(
  parameter int unsigned PAGE_BITS = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  stlb_req_if.sink                    req,
  output logic                        push_valid,
  input  wire logic                   push_ready,
  output logic [PAGE_BITS:0]          push_data
);
  import stlb_pkg::*;

  logic                 held;
  tlb_sel_e             sel;
  logic [PAGE_BITS-1:0] tag;
  tlb_sel_e             sel_next;
  logic [PAGE_BITS+PAGE_W-1:0] page_wide;

  assign req.ready  = !held || push_ready;
  assign push_valid = held;
  assign push_data  = {sel, tag};

  always_comb begin
    page_wide = {{PAGE_BITS{1'b0}}, req.page_number};
    sel_next  = (req.action == 1'b1) ? TLB_DATA : TLB_INSTR;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (req.ready) begin
      held <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      sel <= sel_next;
      tag <= page_wide[PAGE_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/stlb_queue.sv -----
// ----------------------------------------------------------------------------
// Split TLB decoupling queue
// Two-entry queue between the front end and the lookup engine.
// ----------------------------------------------------------------------------
`default_nettype none

module stlb_queue #(
  parameter int unsigned DATA_W = 33
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              wr_valid,
  output logic                   wr_ready,
  input  wire logic [DATA_W-1:0] wr_data,
  output logic                   rd_valid,
  input  wire logic              rd_ready,
  output logic [DATA_W-1:0]      rd_data
);

  logic [DATA_W-1:0] store [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;
  logic              do_wr;
  logic              do_rd;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = store[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_rd) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_wr && !do_rd) begin
        count <= count + 2'd1;
      end else if (do_rd && !do_wr) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      store[wr_ptr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/stlb_back.sv -----
// ----------------------------------------------------------------------------
// Split TLB lookup engine
// Tag compare, FIFO fill, saturating totals and the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module stlb_back #(
  parameter int unsigned ENTRIES   = 16,
  parameter int unsigned PAGE_BITS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               pop_valid,
  output logic                    pop_ready,
  input  wire logic [PAGE_BITS:0] pop_data,
  stlb_cfg_if.sink                cfg,
  stlb_rsp_if.source              rsp
);
  import stlb_pkg::*;

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned NUM_W = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W = (NUM_W > CFG_W) ? NUM_W : CFG_W;

  logic [PAGE_BITS-1:0] tag_mem [2][ENTRIES];
  logic [ENTRIES-1:0]   valid [2];
  logic [IDX_W-1:0]     oldest [2];
  logic [CNT_W-1:0]     hit_total [2];
  logic [CNT_W-1:0]     miss_total [2];
  logic [CFG_W-1:0]     entries;
  result_t              result;
  logic                 rsp_valid;

  tlb_sel_e             sel;
  logic [PAGE_BITS-1:0] tag;
  logic                 do_pop;
  logic [CMP_W-1:0]     active;
  logic [CMP_W-1:0]     limit;
  logic                 hit;
  logic [IDX_W-1:0]     hit_idx;
  logic                 empty_found;
  logic [IDX_W-1:0]     empty_idx;
  logic [CMP_W-1:0]     old_eff;
  logic [CMP_W-1:0]     old_inc;
  logic [IDX_W-1:0]     oldest_next;
  logic [IDX_W-1:0]     fill_idx;
  logic [IDX_W+SLOT_W-1:0] slot_wide;
  logic [CNT_W-1:0]     hit_next;
  logic [CNT_W-1:0]     miss_next;
  result_t              result_next;

  assign sel       = tlb_sel_e'(pop_data[PAGE_BITS]);
  assign tag       = pop_data[PAGE_BITS-1:0];
  assign pop_ready = !rsp_valid || rsp.ready;
  assign do_pop    = pop_valid && pop_ready;
  assign cfg.ready = 1'b1;

  assign rsp.valid      = rsp_valid;
  assign rsp.hit        = result.hit;
  assign rsp.slot       = result.slot;
  assign rsp.hit_count  = result.hit_count;
  assign rsp.miss_count = result.miss_count;

  always_comb begin
    limit = CMP_W'(ENTRIES);
    priority if (entries == '0) begin
      active = CMP_W'(1);
    end else if (CMP_W'(entries) > limit) begin
      active = limit;
    end else begin
      active = CMP_W'(entries);
    end
  end

  always_comb begin
    hit         = 1'b0;
    hit_idx     = '0;
    empty_found = 1'b0;
    empty_idx   = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (CMP_W'(i) < active) begin
        if (valid[sel][i] && (tag_mem[sel][i] == tag)) begin
          hit     = 1'b1;
          hit_idx = IDX_W'(i);
        end
        if (!valid[sel][i]) begin
          empty_found = 1'b1;
          empty_idx   = IDX_W'(i);
        end
      end
    end
  end

  always_comb begin
    old_eff     = (CMP_W'(oldest[sel]) >= active) ? '0 : CMP_W'(oldest[sel]);
    old_inc     = old_eff + CMP_W'(1);
    oldest_next = (old_inc >= active) ? '0 : old_inc[IDX_W-1:0];
    fill_idx    = empty_found ? empty_idx : old_eff[IDX_W-1:0];
    slot_wide   = {{SLOT_W{1'b0}}, (hit ? hit_idx : fill_idx)};
    hit_next    = hit_total[sel];
    miss_next   = miss_total[sel];
    if (hit) begin
      if (hit_next != CNT_MAX) begin
        hit_next = hit_next + CNT_W'(1);
      end
    end else begin
      if (miss_next != CNT_MAX) begin
        miss_next = miss_next + CNT_W'(1);
      end
    end
    result_next.hit        = hit;
    result_next.slot       = slot_wide[SLOT_W-1:0];
    result_next.hit_count  = hit_next;
    result_next.miss_count = miss_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '{default: '0};
      oldest     <= '{default: '0};
      hit_total  <= '{default: '0};
      miss_total <= '{default: '0};
      entries    <= CFG_RESET;
      rsp_valid  <= 1'b0;
    end else begin
      if (cfg.valid) begin
        entries <= cfg.entries_in_use;
      end
      if (do_pop) begin
        rsp_valid       <= 1'b1;
        hit_total[sel]  <= hit_next;
        miss_total[sel] <= miss_next;
        if (!hit) begin
          valid[sel][fill_idx] <= 1'b1;
          if (!empty_found) begin
            oldest[sel] <= oldest_next;
          end
        end
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop) begin
      result <= result_next;
      if (!hit) begin
        tag_mem[sel][fill_idx] <= tag;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/split_tlb_fifo_lookup.sv -----
// A request word passes the front-end register, the queue and the response register
// before its response word is valid. One access per cycle while responses are taken;
// the lookup engine compares all tags of the selected TLB and updates it in one go.
// Reset clears valid bits, replacement pointers, totals and the queue, and sets
// the slot count to 16. No clearing pass is needed; tags are left as they are.
// ----------------------------------------------------------------------------
// Split instruction and data TLB with FIFO replacement
// Front end, decoupling queue and lookup engine for two associative TLBs.
// ----------------------------------------------------------------------------
`default_nettype none

module split_tlb_fifo_lookup #(
  parameter int unsigned ENTRIES   = 16,
  parameter int unsigned PAGE_BITS = 32
) (
  input  wire logic  clk,
  input  wire logic  rst,
  stlb_req_if.sink   req,
  stlb_rsp_if.source rsp,
  stlb_cfg_if.sink   cfg
);
  import stlb_pkg::*;

  logic               push_valid;
  logic               push_ready;
  logic [PAGE_BITS:0] push_data;
  logic               pop_valid;
  logic               pop_ready;
  logic [PAGE_BITS:0] pop_data;

  stlb_front #(
    .PAGE_BITS (PAGE_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  stlb_queue #(
    .DATA_W (PAGE_BITS + 1)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_data  (push_data),
    .rd_valid (pop_valid),
    .rd_ready (pop_ready),
    .rd_data  (pop_data)
  );

  stlb_back #(
    .ENTRIES   (ENTRIES),
    .PAGE_BITS (PAGE_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .cfg       (cfg),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Split TLB lookup testbench
// Drives instruction and data page accesses through the request channel under
// several slot counts, predicts each hit, slot and running totals with its own
// model of the two FIFO-replacement TLBs, and checks every response word.
// ----------------------------------------------------------------------------

module tb;
  import stlb_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int LONG_HOLD   = 300;

  typedef struct {
    tlb_sel_e          action;
    logic [PAGE_W-1:0] page;
  } access_t;

  logic clk;
  logic rst;

  stlb_req_if req_ch ();
  stlb_rsp_if rsp_ch ();
  stlb_cfg_if cfg_ch ();

  split_tlb_fifo_lookup dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // Shadow copy of both TLBs, indexed by the TLB select.
  logic [PAGE_W-1:0] shadow_tags   [2][16];
  logic              shadow_valid  [2][16];
  int unsigned       shadow_oldest [2];
  logic [CNT_W-1:0]  shadow_hits   [2];
  logic [CNT_W-1:0]  shadow_misses [2];
  logic [CFG_W-1:0]  shadow_entries;

  access_t           pending_accesses [$];
  result_t           expected_results [$];
  logic [PAGE_W-1:0] page_pool        [$];

  int  send_gap;
  int  rsp_stall;
  int  hold_token;
  int  hold_seen;
  int  idle_cycles;
  int  errors;
  int  words_checked;
  int  hits_seen;
  int  misses_seen;
  int  settings_used;
  bit  quiet;

  function automatic result_t tlb_lookup_predict(input int sel, input logic [PAGE_W-1:0] page);
    result_t r;
    int      n;
    int      idx;
    bit      found;
    bit      empty_found;
    n = (shadow_entries == '0) ? 1 : ((shadow_entries > 5'd16) ? 16 : int'(shadow_entries));
    found = 1'b0;
    empty_found = 1'b0;
    idx = 0;
    for (int i = 0; i < n; i++) begin
      if (!found && shadow_valid[sel][i] && shadow_tags[sel][i] == page) begin
        found = 1'b1;
        idx = i;
      end
    end
    if (found) begin
      if (shadow_hits[sel] != CNT_MAX) shadow_hits[sel] = shadow_hits[sel] + 1'b1;
    end else begin
      if (shadow_misses[sel] != CNT_MAX) shadow_misses[sel] = shadow_misses[sel] + 1'b1;
      for (int i = 0; i < n; i++) begin
        if (!empty_found && !shadow_valid[sel][i]) begin
          empty_found = 1'b1;
          idx = i;
        end
      end
      if (!empty_found) begin
        if (shadow_oldest[sel] >= n) shadow_oldest[sel] = 0;
        idx = shadow_oldest[sel];
        shadow_oldest[sel] = (idx + 1 >= n) ? 0 : idx + 1;
      end
      shadow_tags[sel][idx] = page;
      shadow_valid[sel][idx] = 1'b1;
    end
    r.hit        = found;
    r.slot       = idx[SLOT_W-1:0];
    r.hit_count  = shadow_hits[sel];
    r.miss_count = shadow_misses[sel];
    return r;
  endfunction

  task automatic queue_access(input tlb_sel_e action, input logic [PAGE_W-1:0] page);
    access_t a;
    a.action = action;
    a.page   = page;
    pending_accesses.push_back(a);
  endtask

  task automatic build_pool(input int size);
    logic [PAGE_W-1:0] p;
    page_pool.delete();
    for (int i = 0; i < size; i++) begin
      case ($urandom_range(0, 9))
        0: p = '0;
        1: p = '1;
        2: p = (page_pool.size() != 0) ? page_pool[0] ^ (32'd1 << $urandom_range(0, 31)) : $urandom();
        default: p = $urandom();
      endcase
      page_pool.push_back(p);
    end
  endtask

  task automatic queue_random(input int count);
    logic [PAGE_W-1:0] p;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 85) p = page_pool[$urandom_range(0, page_pool.size() - 1)];
      else p = $urandom();
      queue_access(tlb_sel_e'($urandom_range(0, 1)), p);
    end
  endtask

  task automatic wait_drained();
    while (pending_accesses.size() != 0 || expected_results.size() != 0 || req_ch.valid)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_entries(input logic [CFG_W-1:0] v);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.entries_in_use <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    shadow_entries = v;
    cfg_ch.valid <= 1'b0;
    settings_used++;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Request side: one word from the pending queue at a time, with idle bursts.
  always @(posedge clk) begin
    access_t nxt;
    if (rst) begin
      req_ch.valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (req_ch.valid && req_ch.ready)
        expected_results.push_back(tlb_lookup_predict(int'(req_ch.action), req_ch.page_number));
      if (req_ch.valid && !req_ch.ready) begin
      end else if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        req_ch.valid <= 1'b0;
      end else if (pending_accesses.size() != 0) begin
        nxt = pending_accesses.pop_front();
        req_ch.valid <= 1'b1;
        req_ch.action <= nxt.action;
        req_ch.page_number <= nxt.page;
        if (!quiet && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 15);
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Response side: checks each word against the oldest prediction.
  always @(posedge clk) begin
    result_t exp_r;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      rsp_stall <= 0;
      hold_seen <= 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        words_checked++;
        if (rsp_ch.hit === 1'b1) hits_seen++;
        else misses_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t: response word with nothing expected (hit %b slot %0d)",
                   $time, rsp_ch.hit, rsp_ch.slot);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (rsp_ch.hit !== exp_r.hit) begin
            $display("%0t: hit expected %b actual %b", $time, exp_r.hit, rsp_ch.hit);
            errors++;
          end
          if (rsp_ch.slot !== exp_r.slot) begin
            $display("%0t: slot expected %0d actual %0d", $time, exp_r.slot, rsp_ch.slot);
            errors++;
          end
          if (rsp_ch.hit_count !== exp_r.hit_count) begin
            $display("%0t: hit_count expected %0d actual %0d",
                     $time, exp_r.hit_count, rsp_ch.hit_count);
            errors++;
          end
          if (rsp_ch.miss_count !== exp_r.miss_count) begin
            $display("%0t: miss_count expected %0d actual %0d",
                     $time, exp_r.miss_count, rsp_ch.miss_count);
            errors++;
          end
        end
      end
      if (hold_seen != hold_token) begin
        hold_seen <= hold_token;
        rsp_stall <= LONG_HOLD - 1;
        rsp_ch.ready <= 1'b0;
      end else if (rsp_stall != 0) begin
        rsp_stall <= rsp_stall - 1;
        rsp_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        rsp_stall <= $urandom_range(0, 14);
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
      $display("split_tlb_fifo_lookup: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [CFG_W-1:0] settings [9];
    int               n;
    settings = '{5'd1, 5'd0, 5'd31, 5'd17, 5'd5, 5'd3, 5'd16, 5'd8, 5'd16};
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.action = 1'b0;
    req_ch.page_number = '0;
    rsp_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.entries_in_use = '0;
    hold_token = 0;
    idle_cycles = 0;
    errors = 0;
    words_checked = 0;
    hits_seen = 0;
    misses_seen = 0;
    settings_used = 1;
    quiet = 1'b0;
    shadow_entries = CFG_RESET;
    for (int t = 0; t < 2; t++) begin
      shadow_oldest[t] = 0;
      shadow_hits[t] = '0;
      shadow_misses[t] = '0;
      for (int i = 0; i < 16; i++) begin
        shadow_valid[t][i] = 1'b0;
        shadow_tags[t][i] = '0;
      end
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Extremes, hits in both TLBs, filling every instruction slot, then round-robin replacement.
    queue_access(TLB_INSTR, 32'h0000_0000);
    queue_access(TLB_INSTR, 32'h0000_0000);
    queue_access(TLB_INSTR, 32'hFFFF_FFFF);
    queue_access(TLB_DATA, 32'hFFFF_FFFF);
    queue_access(TLB_DATA, 32'hFFFF_FFFF);
    queue_access(TLB_DATA, 32'h0000_0000);
    for (int i = 2; i < 16; i++) queue_access(TLB_INSTR, 32'h0000_1000 + i);
    queue_access(TLB_INSTR, 32'h1234_5678);
    queue_access(TLB_INSTR, 32'h0000_0000);
    queue_access(TLB_INSTR, 32'hFFFF_FFFF);
    queue_access(TLB_INSTR, 32'h1234_5678);
    wait_drained();

    foreach (settings[s]) begin
      if (s == 8) quiet <= 1'b1;
      write_entries(settings[s]);
      n = (settings[s] == '0) ? 1 : ((settings[s] > 5'd16) ? 16 : int'(settings[s]));
      build_pool($urandom_range((n > 1) ? n - 1 : 1, 2 * n + 2));
      queue_random(125);
      if (s == 2) begin
        repeat (2) @(posedge clk);
        hold_token <= hold_token + 1;
      end
      wait_drained();
    end

    repeat (10) @(posedge clk);
    $display("Checked %0d response words (%0d hits, %0d misses).", words_checked, hits_seen,
             misses_seen);
    $display("Slot counts used: %0d, including zero, one, sixteen and above sixteen.",
             settings_used);
    if (errors == 0) begin
      $display("split_tlb_fifo_lookup: match");
    end else begin
      $display("split_tlb_fifo_lookup: mismatch");
    end
    $finish;
  end

endmodule
